FILE: src/tad_pkg.sv
// shared widths, constants, register indexes and divider control types
`timescale 1ns / 1ps

package tad_pkg;

  localparam int unsigned ADC_W      = 10;
  localparam int unsigned BETA_W     = 13;
  localparam int unsigned TEMP_W     = 20;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = BETA_W;

  localparam int unsigned ADC_FULL_SCALE_DEF = 1023;
  localparam int unsigned DIV_W_DEF          = 35;
  localparam int unsigned DIV_CNT_W          = 6;

  // fixed point scales and constants of the beta equation
  localparam int unsigned FX_R_LG      = 13;
  localparam int unsigned FX_R         = 8192;
  localparam int unsigned T_SCALE_LG   = 10;
  localparam int unsigned INV_T0       = 14067;
  localparam int unsigned CENTI_NUM    = 419430400;
  localparam int unsigned KELVIN_CENTI = 27315;
  localparam int unsigned TEMP_MAX     = 400000;
  localparam int unsigned BETA_RESET   = 3950;

  // widths of the log quotient, the log, and the dividends of the last two divisions
  localparam int unsigned LN_Q_W  = 15;
  localparam int unsigned LN_W    = 18;
  localparam int unsigned T_DIV_N = 28;
  localparam int unsigned R_DIV_N = 29;

  localparam logic [CFG_IDX_W-1:0] REG_BETA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RAW  = CFG_IDX_W'(1);

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: src/tad_if.sv
// stream interfaces for the adc word, the temperature word and config writes
`timescale 1ns / 1ps

interface tad_adc_if;
  logic                        valid;
  logic                        ready;
  logic [tad_pkg::ADC_W-1:0]   adc_reading;
  modport source (output valid, output adc_reading, input ready);
  modport sink (input valid, input adc_reading, output ready);
endinterface

interface tad_temp_if;
  logic                               valid;
  logic                               ready;
  logic signed [tad_pkg::TEMP_W-1:0]  temperature_value;
  logic                               shorted;
  modport source (output valid, output temperature_value, output shorted, input ready);
  modport sink (input valid, input temperature_value, input shorted, output ready);
endinterface

interface tad_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tad_pkg::CFG_IDX_W-1:0]    index;
  logic [tad_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/tad_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tad_div #(
  parameter int unsigned W = tad_pkg::DIV_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tad_pkg::div_ctl_t ctl_i,
  input  logic [W-1:0]      dividend_i,
  input  logic [W-1:0]      divisor_i,
  output tad_pkg::div_sts_t sts_o,
  output logic [W-1:0]      quotient_o
);
  import tad_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]         rem_q, rem_d;
  logic [W-1:0]         quo_q, quo_d;
  logic [W-1:0]         dsr_q, dsr_d;
  logic [W:0]           shifted;
  logic [W+1:0]         diff;
  logic                 ge;

  // dividend comes in left aligned, its bits leave at the top as quotient bits enter below
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    ge      = ~diff[W+1];
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ctl_i.iters;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/thermistor_adc_to_centidegrees.sv
// thermistor adc reading to centidegrees celsius via the beta equation
`timescale 1ns / 1ps

// channel  modport  word
// -------  -------  --------------------------------------------------
// cfg_i    sink     index, data: 0 = beta_kelvin, 1 = raw_mode
// adc_i    sink     adc_reading (10 bit unsigned)
// temp_o   source   temperature_value (20 bit signed), shorted
//
// a converted reading goes from accept to the output register through the one shared
// bit-serial divider (N1 = 13 + bits of full scale, DW = N1 + 12) and SQN square root
// steps; the divider runs up to four divisions at one quotient bit a cycle, the root
// takes 2 bits a cycle
// raw and zero readings skip the divider; adc_i.ready returns in the same cycle as the
// word moves to the output register
// one reading at a time; adc_i.ready is high only between items
// a finished word waits in the output register, the next reading is taken meanwhile
// reset sets beta to 3950 and clears raw mode; config writes are always taken

module thermistor_adc_to_centidegrees #(
  parameter int unsigned ADC_FULL_SCALE = tad_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tad_cfg_if.sink     cfg_i,
  tad_adc_if.sink     adc_i,
  tad_temp_if.source  temp_o
);
  import tad_pkg::*;

  // widths that follow from the full scale
  localparam int unsigned FSW  = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned N1   = FSW + FX_R_LG;          // bits of fs * 8192 / adc
  localparam int unsigned DW   = N1 + 12;                // widest dividend, the log numerator
  localparam int unsigned DENW = N1 + 1;
  localparam int unsigned SQN  = (FSW + 2 * FX_R_LG + 1) / 2;
  localparam int unsigned SQW  = 2 * SQN;
  localparam int unsigned SQCW = $clog2(SQN + 1);

  // dividends of the first and last division, left aligned for the divider
  localparam logic [DW-1:0] D1_NUM = DW'(ADC_FULL_SCALE) << (DW - N1 + FX_R_LG);
  localparam logic [DW-1:0] D4_NUM = DW'(CENTI_NUM) << (DW - R_DIV_N);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a reading
  localparam logic [2:0] S_X    = 3'd1;  // ratio division
  localparam logic [2:0] S_SQ   = 3'd2;  // square root steps
  localparam logic [2:0] S_LN   = 3'd3;  // launch log division
  localparam logic [2:0] S_T    = 3'd4;  // log division
  localparam logic [2:0] S_D    = 3'd5;  // division by beta
  localparam logic [2:0] S_R    = 3'd6;  // final reciprocal
  localparam logic [2:0] S_OUT  = 3'd7;  // hand result to output register

  logic [2:0]               state_q, state_d;
  logic [BETA_W-1:0]        beta_q;
  logic                     raw_q;
  logic [N1-1:0]            q1_q, q1_d;
  logic [SQW-1:0]           sq_op_q, sq_op_d;
  logic [SQN+1:0]           sq_rem_q, sq_rem_d;
  logic [SQN-1:0]           sq_root_q, sq_root_d;
  logic [SQCW-1:0]          sq_cnt_q, sq_cnt_d;
  logic                     ln_neg_q, ln_neg_d;
  logic signed [TEMP_W-1:0] res_val_q, res_val_d;
  logic                     res_sh_q, res_sh_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [TEMP_W-1:0] out_val_q, out_val_d;
  logic                     out_sh_q, out_sh_d;

  div_ctl_t                 div_ctl;
  div_sts_t                 div_sts;
  logic [DW-1:0]            div_dividend;
  logic [DW-1:0]            div_divisor;
  logic [DW-1:0]            quo;

  logic                     accept;
  logic                     out_free;
  logic [N1-1:0]            qx;
  logic                     num_neg;
  logic [N1-1:0]            num_mag;
  logic [DENW-1:0]          den;
  logic [BETA_W-1:0]        beta_eff;
  logic [LN_W-1:0]          ln_mag;
  logic [T_DIV_N-1:0]       q3;
  logic                     d_sat;
  logic [R_DIV_N-1:0]       d_pos;
  logic [R_DIV_N-1:0]       q4;
  logic                     hot;
  logic [SQN+3:0]           sq_cat;
  logic [SQN+3:0]           sq_trial;
  logic [SQN+3:0]           sq_diff;
  logic                     sq_ge;

  assign accept   = adc_i.valid && adc_i.ready;
  assign out_free = !out_valid_q || temp_o.ready;

  assign adc_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // config registers; the user must write them only between items, the block itself does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_W'(BETA_RESET);
      raw_q  <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == REG_BETA) begin
        beta_q <= cfg_i.data;
      end else if (cfg_i.index == REG_RAW) begin
        raw_q <= cfg_i.data[0];
      end
    end
  end

  // datapath terms, all kept unsigned with explicit sign flags
  always_comb begin
    // q1 = fs*8192/adc, so x = q1 - 8192 and x - 8192 = q1 - 16384
    qx       = quo[N1-1:0];
    num_neg  = q1_q < N1'(2 * FX_R);
    num_mag  = num_neg ? (N1'(2 * FX_R) - q1_q) : (q1_q - N1'(2 * FX_R));
    // q1 stays above 2000 for any nonzero reading, so the log denominator is positive
    den      = DENW'(q1_q) + (DENW'(sq_root_q) << 2);
    beta_eff = (beta_q == '0) ? BETA_W'(1) : beta_q;
    // ln magnitude = 6 * quotient
    ln_mag   = (LN_W'(quo[LN_Q_W-1:0]) << 2) + (LN_W'(quo[LN_Q_W-1:0]) << 1);
    q3       = quo[T_DIV_N-1:0];
    d_sat    = !ln_neg_q && (q3 >= T_DIV_N'(INV_T0));
    d_pos    = ln_neg_q ? (R_DIV_N'(q3) + R_DIV_N'(INV_T0))
                        : (R_DIV_N'(INV_T0) - R_DIV_N'(q3));
    q4       = quo[R_DIV_N-1:0];
    hot      = q4 > R_DIV_N'(TEMP_MAX + KELVIN_CENTI);
    // one digit-by-digit square root step, two operand bits a cycle
    sq_cat   = {sq_rem_q, sq_op_q[SQW-1 -: 2]};
    sq_trial = (SQN+4)'({sq_root_q, 2'b01});
    sq_diff  = sq_cat - sq_trial;
    sq_ge    = sq_cat >= sq_trial;
  end

  // sequencer and divider launches
  always_comb begin
    state_d      = state_q;
    q1_d         = q1_q;
    sq_op_d      = sq_op_q;
    sq_rem_d     = sq_rem_q;
    sq_root_d    = sq_root_q;
    sq_cnt_d     = sq_cnt_q;
    ln_neg_d     = ln_neg_q;
    res_val_d    = res_val_q;
    res_sh_d     = res_sh_q;
    out_valid_d  = out_valid_q && !temp_o.ready;
    out_val_d    = out_val_q;
    out_sh_d     = out_sh_q;
    div_ctl      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (raw_q) begin
            res_val_d = TEMP_W'(adc_i.adc_reading);
            res_sh_d  = 1'b0;
            state_d   = S_OUT;
          end else if (adc_i.adc_reading == '0) begin
            // shorted thermistor
            res_val_d = '0;
            res_sh_d  = 1'b1;
            state_d   = S_OUT;
          end else begin
            div_ctl.start = 1'b1;
            div_ctl.iters = DIV_CNT_W'(N1);
            div_dividend  = D1_NUM;
            div_divisor   = DW'(adc_i.adc_reading);
            res_sh_d      = 1'b0;
            state_d       = S_X;
          end
        end
      end
      S_X: begin
        if (div_sts.done) begin
          q1_d      = qx;
          // root of 8192 * x, zero when x is not positive
          sq_op_d   = (qx > N1'(FX_R)) ? (SQW'(qx - N1'(FX_R)) << FX_R_LG) : '0;
          sq_rem_d  = '0;
          sq_root_d = '0;
          sq_cnt_d  = SQCW'(SQN);
          state_d   = S_SQ;
        end
      end
      S_SQ: begin
        sq_rem_d  = sq_ge ? sq_diff[SQN+1:0] : sq_cat[SQN+1:0];
        sq_root_d = {sq_root_q[SQN-2:0], sq_ge};
        sq_op_d   = sq_op_q << 2;
        sq_cnt_d  = sq_cnt_q - SQCW'(1);
        if (sq_cnt_q == SQCW'(1)) begin
          state_d = S_LN;
        end
      end
      S_LN: begin
        div_ctl.start = 1'b1;
        div_ctl.iters = DIV_CNT_W'(DW);
        div_dividend  = {num_mag, 12'b0};
        div_divisor   = DW'(den);
        ln_neg_d      = num_neg;
        state_d       = S_T;
      end
      S_T: begin
        if (div_sts.done) begin
          div_ctl.start = 1'b1;
          div_ctl.iters = DIV_CNT_W'(T_DIV_N);
          div_dividend  = DW'(ln_mag) << (DW - T_DIV_N + T_SCALE_LG);
          div_divisor   = DW'(beta_eff);
          state_d       = S_D;
        end
      end
      S_D: begin
        if (div_sts.done) begin
          if (d_sat) begin
            // inverse temperature not positive
            res_val_d = TEMP_W'(TEMP_MAX);
            state_d   = S_OUT;
          end else begin
            div_ctl.start = 1'b1;
            div_ctl.iters = DIV_CNT_W'(R_DIV_N);
            div_dividend  = D4_NUM;
            div_divisor   = DW'(d_pos);
            state_d       = S_R;
          end
        end
      end
      S_R: begin
        if (div_sts.done) begin
          res_val_d = hot ? TEMP_W'(TEMP_MAX)
                          : (TEMP_W'(q4) - TEMP_W'(KELVIN_CENTI));
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_sh_d    = res_sh_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sq_cnt_q    <= sq_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q      <= q1_d;
    sq_op_q   <= sq_op_d;
    sq_rem_q  <= sq_rem_d;
    sq_root_q <= sq_root_d;
    ln_neg_q  <= ln_neg_d;
    res_val_q <= res_val_d;
    res_sh_q  <= res_sh_d;
    out_val_q <= out_val_d;
    out_sh_q  <= out_sh_d;
  end

  // shared divider for all four divisions
  tad_div #(
    .W (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (quo)
  );

  assign temp_o.valid             = out_valid_q;
  assign temp_o.temperature_value = out_val_q;
  assign temp_o.shorted           = out_sh_q;

  // divider is launched only when free
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider launched while busy");

  // a reading is taken only when no division is in flight
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!div_sts.busy && !div_sts.done))
    else $error("reading taken during a conversion");

  // shorted word carries a zero value
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (temp_o.valid && temp_o.shorted) |-> (temp_o.temperature_value == '0))
    else $error("shorted word with nonzero value");

  // output never exceeds the saturation limit
  a_temp_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    temp_o.valid |-> (temp_o.temperature_value <= $signed(TEMP_W'(TEMP_MAX))))
    else $error("temperature above saturation limit");

endmodule

FILE: tb/sv/tb_thermistor_adc_to_centidegrees.sv
// self-checking testbench for the thermistor adc to centidegrees converter
`timescale 1ns / 1ps

module tb_thermistor_adc_to_centidegrees;
  import tad_pkg::*;

  // signed copies of the package constants, so the predictor math stays signed
  localparam longint SCALE_R     = longint'(FX_R);
  localparam longint SCALE_LN    = 4096;
  localparam longint FULL_SCALE  = longint'(ADC_FULL_SCALE_DEF);
  localparam longint INV_T0_FX   = longint'(INV_T0);
  localparam longint CENTI_FX    = longint'(CENTI_NUM);
  localparam longint KELVIN_FX   = longint'(KELVIN_CENTI);
  localparam longint TEMP_CAP    = longint'(TEMP_MAX);
  localparam longint T_SCALE     = longint'(1) << T_SCALE_LG;

  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  // one temperature word as it leaves the block
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     shorted;
  } centi_word_t;

  typedef enum logic [0:0] {
    ROW_CFG,
    ROW_ADC
  } row_kind_e;

  // one directed step: a register write or a reading, with an optional typed-in answer
  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    value;
    logic                     pinned;
    logic signed [TEMP_W-1:0] pin_temp;
    logic                     pin_shorted;
  } dir_row_t;

  // one random phase: beta range, raw mode and number of readings
  typedef struct packed {
    logic [BETA_W-1:0] beta_lo;
    logic [BETA_W-1:0] beta_hi;
    logic              raw;
    logic [15:0]       count;
  } phase_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tad_cfg_if  cfg_if ();
  tad_adc_if  adc_if ();
  tad_temp_if temp_if ();

  thermistor_adc_to_centidegrees u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .adc_i  (adc_if),
    .temp_o (temp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the two registers, updated when a write is taken
  logic [BETA_W-1:0] beta_shadow = BETA_W'(BETA_RESET);
  logic              raw_shadow  = 1'b0;

  centi_word_t centi_expected [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_tail  = 1'b0;
  bit          adc_held    = 1'b0;

  wire adc_fire  = adc_if.valid && adc_if.ready;
  wire temp_fire = temp_if.valid && temp_if.ready;
  wire cfg_fire  = cfg_if.valid && cfg_if.ready;

  // bitwise integer square root, floor of sqrt(v)
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // beta equation in fixed point: ratio at 2^13, log at 2^12, 1/T at 2^22
  function automatic centi_word_t predict_centi(logic [ADC_W-1:0] adc,
                                                logic [BETA_W-1:0] beta, logic raw);
    centi_word_t w;
    longint      a;
    longint      b;
    longint      ratio;
    longint      root;
    longint      num;
    longint      den;
    longint      ln_fx;
    longint      inv_t;
    longint      d;
    longint      v;
    a         = longint'(adc);
    w.shorted = 1'b0;
    if (raw) begin
      v = a;
    end else if (a == 0) begin
      // shorted thermistor
      v         = 0;
      w.shorted = 1'b1;
    end else begin
      b     = (beta == '0) ? longint'(1) : longint'(beta);
      ratio = (SCALE_R * FULL_SCALE) / a - SCALE_R;
      root  = (ratio > 0) ? longint'(int_sqrt(longint'(ratio * SCALE_R))) : longint'(0);
      // borchardt: ln(r) ~ 6(r-1)/(r+1+4 sqrt r)
      num   = SCALE_LN * (ratio - SCALE_R);
      den   = ratio + SCALE_R + 4 * root;
      if (den <= 0) den = 1;
      ln_fx = (num / den) * 6;
      inv_t = (T_SCALE * ln_fx) / b;
      d     = INV_T0_FX - inv_t;
      if (d <= 0) begin
        v = TEMP_CAP;
      end else begin
        v = CENTI_FX / d - KELVIN_FX;
        if (v > TEMP_CAP) v = TEMP_CAP;
      end
    end
    w.temp = v[TEMP_W-1:0];
    return w;
  endfunction

  // directed steps: extremes of the reading, beta extremes, shorted and raw cases
  dir_row_t directed_rows [$] = '{
    // defaults after reset: beta 3950, conversion on
    '{ROW_ADC, REG_BETA, 13'd0,    1'b1, 20'sd0,    1'b1},
    '{ROW_ADC, REG_BETA, 13'd1,    1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd2,    1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd512,  1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1022, 1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1023, 1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd341,  1'b0, 20'sd0,    1'b0},
    // beta of zero acts as one; hot readings saturate
    '{ROW_CFG, REG_BETA, 13'd0,    1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1023, 1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1,    1'b1, 20'sd400000, 1'b0},
    '{ROW_ADC, REG_BETA, 13'd0,    1'b1, 20'sd0,    1'b1},
    // largest beta the register holds
    '{ROW_CFG, REG_BETA, 13'd8191, 1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1,    1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1023, 1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd100,  1'b0, 20'sd0,    1'b0},
    '{ROW_CFG, REG_BETA, 13'd2000, 1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd5,    1'b0, 20'sd0,    1'b0},
    '{ROW_CFG, REG_BETA, 13'd6000, 1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd5,    1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1000, 1'b0, 20'sd0,    1'b0},
    // raw mode passes the reading through, zero included, never shorted
    '{ROW_CFG, REG_RAW,  13'd1,    1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd0,    1'b1, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd1023, 1'b1, 20'sd1023, 1'b0},
    '{ROW_ADC, REG_BETA, 13'd682,  1'b1, 20'sd682,  1'b0},
    '{ROW_CFG, REG_RAW,  13'd0,    1'b0, 20'sd0,    1'b0},
    '{ROW_ADC, REG_BETA, 13'd0,    1'b1, 20'sd0,    1'b1}
  };

  // random phases; the last one runs with no idling on either side
  phase_t phase_plan [$] = '{
    '{13'd3950, 13'd3950, 1'b0, 16'd220},
    '{13'd2000, 13'd2000, 1'b0, 16'd180},
    '{13'd6000, 13'd6000, 1'b0, 16'd180},
    '{13'd2000, 13'd6000, 1'b0, 16'd180},
    '{13'd8191, 13'd8191, 1'b0, 16'd80},
    '{13'd0,    13'd1,    1'b0, 16'd60},
    '{13'd0,    13'd8191, 1'b1, 16'd100},
    '{13'd3950, 13'd3950, 1'b0, 16'd330}
  };

  // drop valid, let every outstanding word drain, then a short hold-off
  task automatic settle();
    if (adc_held) begin
      adc_if.valid <= 1'b0;
      adc_held = 1'b0;
    end
    while (centi_expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_BETA) beta_shadow = data[BETA_W-1:0];
    else if (idx == REG_RAW) raw_shadow = data[0];
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one reading; on acceptance queue its expected word, then maybe idle
  task automatic send_reading(input logic [ADC_W-1:0] adc, input logic pinned,
                              input centi_word_t pin_word);
    adc_if.valid       <= 1'b1;
    adc_if.adc_reading <= adc;
    adc_held = 1'b1;
    do @(posedge clk_i); while (!adc_if.ready);
    centi_expected.push_back(pinned ? pin_word : predict_centi(adc, beta_shadow, raw_shadow));
    // sender gap, skipped in the quiet tail
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      adc_if.valid <= 1'b0;
      adc_held = 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // receiver: ready drops in bursts until the quiet tail
  initial begin
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        temp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        temp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // compare each taken word with the oldest expectation
  always @(posedge clk_i) begin
    centi_word_t want;
    if (rst_ni && temp_fire) begin
      if (centi_expected.size() == 0) begin
        $display("%0t: unexpected word: temperature_value %0d shorted %0b", $time,
                 temp_if.temperature_value, temp_if.shorted);
        mismatches++;
      end else begin
        want = centi_expected.pop_front();
        if (temp_if.temperature_value !== want.temp) begin
          $display("%0t: temperature_value mismatch: expected %0d actual %0d", $time,
                   want.temp, temp_if.temperature_value);
          mismatches++;
        end
        if (temp_if.shorted !== want.shorted) begin
          $display("%0t: shorted mismatch: expected %0b actual %0b", $time,
                   want.shorted, temp_if.shorted);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles in which no channel moves a word
  always @(posedge clk_i) begin
    if (!rst_ni || adc_fire || temp_fire || cfg_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t        row;
    phase_t          ph;
    centi_word_t     pin;
    centi_word_t     no_pin;
    logic [ADC_W-1:0] adc;
    int unsigned     pick;
    no_pin = '0;

    rst_ni             <= 1'b0;
    adc_if.valid       <= 1'b0;
    adc_if.adc_reading <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_BETA;
    cfg_if.data        <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        write_reg(row.reg_idx, row.value);
      end else begin
        pin.temp    = row.pin_temp;
        pin.shorted = row.pin_shorted;
        send_reading(row.value[ADC_W-1:0], row.pinned, pin);
      end
    end

    // random part, one register setting per phase
    foreach (phase_plan[p]) begin
      ph = phase_plan[p];
      settle();
      if (p == phase_plan.size() - 1) quiet_tail = 1'b1;
      write_reg(REG_BETA, CFG_DATA_W'($urandom_range(ph.beta_lo, ph.beta_hi)));
      write_reg(REG_RAW, CFG_DATA_W'(ph.raw));
      for (int unsigned n = 0; n < ph.count; n++) begin
        // bias toward hot (small) and cold (near full scale) readings, some shorts
        pick = $urandom_range(0, 15);
        if (pick == 0)      adc = '0;
        else if (pick < 4)  adc = ADC_W'($urandom_range(1, 31));
        else if (pick < 6)  adc = ADC_W'($urandom_range(990, 1023));
        else                adc = ADC_W'($urandom_range(0, 1023));
        send_reading(adc, 1'b0, no_pin);
      end
    end

    // drain, then give the block time to show any stray word
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
